### rtl/deferred_work_priority_queue_defines.svh
// Assertion macros used by the top RTL file of the deferred work queue.
`ifndef DEFERRED_WORK_PRIORITY_QUEUE_DEFINES_SVH
`define DEFERRED_WORK_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
`define DWPQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("deferred work queue assertion failed");
`define DWPQ_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("deferred work queue forbidden condition seen");
`else
`define DWPQ_ASSERT(lbl, clk, rstn, prop)
`define DWPQ_NEVER(lbl, clk, rstn, expr)
`endif

`endif

### rtl/dwpq_pkg.sv
package dwpq_pkg;

  localparam int NUM_SLOTS_DEF = 32;

  localparam int SLOT_W  = 5;
  localparam int PRIO_W  = 2;
  localparam int ARG_W   = 64;
  localparam int DEPTH_W = 6;
  localparam int THR_W   = 6;

  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 144;

  localparam logic [THR_W-1:0]  THRESHOLD_RESET = 6'd4;
  localparam logic [PRIO_W-1:0] PRIO_LOW        = 2'd0;
  localparam logic [PRIO_W-1:0] PRIO_HIGH       = 2'd2;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_REMOVE   = 2'd1,
    CMD_RETIRE   = 2'd2,
    CMD_DISPATCH = 2'd3
  } cmd_e;

endpackage

### rtl/dwpq_link_ram.sv
module dwpq_link_ram
  import dwpq_pkg::*;
#(
  parameter int Depth = NUM_SLOTS_DEF,
  parameter int AW    = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [AW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [AW-1:0] rdata_o
);

  logic [AW-1:0] mem [Depth];
  logic [AW-1:0] rd_q;
  logic [AW-1:0] byp_data_q;
  logic          byp_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q       <= mem[raddr_i];
      byp_data_q <= wdata_i;
    end
  end

  // A read issued in the same cycle as a write to the same entry returns the new value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (re_i) begin
      byp_q <= we_i && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = byp_q ? byp_data_q : rd_q;

endmodule

### rtl/deferred_work_priority_queue.sv
// Deferred work queue over a fixed set of object slots.
// Requests arrive on the s_axis channel: tuser carries the command (insert,
// remove, retire next, request dispatch), tdata the slot, priority and two
// argument words. Each request produces exactly one result on the m_axis
// channel: done flag, interrupt request, popped slot and its arguments, and
// the queue depth and empty flag after the request.
// The low priority threshold is written on the cfg channel, which is always
// ready; write it only while no request is in flight.
// A request waits in the input register, where it reads its link entries,
// and its result is loaded into the output register when it commits. One
// request is taken every cycle unless the receiver stalls; the link
// memories and the argument memory each see one read and one write per
// cycle, which sets that rate.
// Reset empties the queue, clears the dispatch flags and sets the threshold
// to 4; no clearing pass is needed. When the receiver stalls, the output
// register holds its result and the input register still takes one more
// request before s_axis_tready drops.
`include "deferred_work_priority_queue_defines.svh"

module deferred_work_priority_queue
  import dwpq_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // object_slot, priority_level, first_argument, second_argument, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // command
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // done_res, raise_interrupt, popped_slot, popped_first_argument,
  // popped_second_argument, queue_empty, queue_depth, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [THR_W-1:0]      cfg_data_i
);

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int DW = $clog2(NUM_SLOTS + 1);

  logic                 in_valid_q;
  cmd_e                 cmd_q;
  logic [SLOT_W-1:0]    slot_q;
  logic [PRIO_W-1:0]    prio_q;
  logic [ARG_W-1:0]     arg1_q;
  logic [ARG_W-1:0]     arg2_q;

  logic [NUM_SLOTS-1:0] mark_q, mark_d;
  logic [SW-1:0]        head_q, head_d;
  logic [SW-1:0]        tail_q, tail_d;
  logic [DW-1:0]        depth_q, depth_d;
  logic                 active_q, active_d;
  logic                 pending_q, pending_d;
  logic [THR_W-1:0]     thr_q;

  logic                 out_valid_q;
  logic                 done_q, raise_q, popped_q, empty_q;
  logic [SLOT_W-1:0]    pslot_q;
  logic [DEPTH_W-1:0]   qdepth_q;
  logic [2*ARG_W-1:0]   arg_rd_q;
  logic [2*ARG_W-1:0]   arg_mem [NUM_SLOTS];

  logic                 advance, commit, accept;
  logic                 done_d, raise_d, pop_d, arg_we;
  logic [SW-1:0]        sidx, ul_slot, nx, pv, raddr;
  logic                 do_unlink;
  logic                 nl_we, pl_we;
  logic [SW-1:0]        nl_wa, nl_wd, pl_wa, pl_wd;
  logic [DW-1:0]        depth_inc;

  assign advance       = !out_valid_q || m_axis_tready;
  assign commit        = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign sidx      = SW'(slot_q);
  assign depth_inc = depth_q + DW'(1);

  always_comb begin
    mark_d    = mark_q;
    head_d    = head_q;
    tail_d    = tail_q;
    depth_d   = depth_q;
    active_d  = active_q;
    pending_d = pending_q;
    done_d    = 1'b0;
    raise_d   = 1'b0;
    pop_d     = 1'b0;
    arg_we    = 1'b0;
    do_unlink = 1'b0;
    ul_slot   = sidx;
    nl_we     = 1'b0;
    nl_wa     = sidx;
    nl_wd     = head_q;
    pl_we     = 1'b0;
    pl_wa     = head_q;
    pl_wd     = sidx;
    unique case (cmd_q)
      CMD_INSERT: begin
        if ((32'(slot_q) < NUM_SLOTS) && !mark_q[sidx]) begin
          depth_d      = depth_inc;
          arg_we       = 1'b1;
          mark_d[sidx] = 1'b1;
          done_d       = 1'b1;
          if (depth_q == '0) begin
            head_d = sidx;
            tail_d = sidx;
          end else if (prio_q >= PRIO_HIGH) begin
            nl_we  = 1'b1;
            nl_wa  = sidx;
            nl_wd  = head_q;
            pl_we  = 1'b1;
            pl_wa  = head_q;
            pl_wd  = sidx;
            head_d = sidx;
          end else begin
            pl_we  = 1'b1;
            pl_wa  = sidx;
            pl_wd  = tail_q;
            nl_we  = 1'b1;
            nl_wa  = tail_q;
            nl_wd  = sidx;
            tail_d = sidx;
          end
          if (!active_q && !pending_q &&
              (prio_q != PRIO_LOW || 32'(depth_inc) >= 32'(thr_q))) begin
            pending_d = 1'b1;
            raise_d   = 1'b1;
          end
        end
      end
      CMD_REMOVE: begin
        if ((32'(slot_q) < NUM_SLOTS) && mark_q[sidx]) begin
          do_unlink = 1'b1;
          ul_slot   = sidx;
          done_d    = 1'b1;
        end
      end
      CMD_RETIRE: begin
        if (depth_q == '0) begin
          active_d  = 1'b0;
          pending_d = 1'b0;
        end else begin
          active_d  = 1'b1;
          pop_d     = 1'b1;
          do_unlink = 1'b1;
          ul_slot   = head_q;
          done_d    = 1'b1;
        end
      end
      CMD_DISPATCH: begin
        pending_d = 1'b1;
        raise_d   = !active_q;
      end
      default: ;
    endcase
    if (do_unlink) begin
      if (depth_q > DW'(1)) begin
        if (ul_slot == head_q) begin
          head_d = nx;
        end else if (ul_slot == tail_q) begin
          tail_d = pv;
        end else begin
          nl_we = 1'b1;
          nl_wa = pv;
          nl_wd = nx;
          pl_we = 1'b1;
          pl_wa = nx;
          pl_wd = pv;
        end
      end
      mark_d[ul_slot] = 1'b0;
      if (depth_q != '0) begin
        depth_d = depth_q - DW'(1);
      end
    end
  end

  // Link entries are read as the request enters, at the head it will see.
  assign raddr = (cmd_e'(s_axis_tuser) == CMD_RETIRE) ? (commit ? head_d : head_q)
                                                     : SW'(s_axis_tdata[SLOT_W-1:0]);

  dwpq_link_ram #(.Depth(NUM_SLOTS), .AW(SW)) u_next_link (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (commit && nl_we),
    .waddr_i (nl_wa),
    .wdata_i (nl_wd),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (nx)
  );

  dwpq_link_ram #(.Depth(NUM_SLOTS), .AW(SW)) u_prev_link (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (commit && pl_we),
    .waddr_i (pl_wa),
    .wdata_i (pl_wd),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (pv)
  );

  always_ff @(posedge clk_i) begin
    if (commit && arg_we) begin
      arg_mem[sidx] <= {arg2_q, arg1_q};
    end
    if (commit) begin
      arg_rd_q <= arg_mem[head_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mark_q      <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      depth_q     <= '0;
      active_q    <= 1'b0;
      pending_q   <= 1'b0;
      thr_q       <= THRESHOLD_RESET;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (commit) begin
        in_valid_q <= 1'b0;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
        mark_q      <= mark_d;
        head_q      <= head_d;
        tail_q      <= tail_d;
        depth_q     <= depth_d;
        active_q    <= active_d;
        pending_q   <= pending_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_e'(s_axis_tuser);
      slot_q <= s_axis_tdata[SLOT_W-1:0];
      prio_q <= s_axis_tdata[SLOT_W+PRIO_W-1:SLOT_W];
      arg1_q <= s_axis_tdata[SLOT_W+PRIO_W+ARG_W-1:SLOT_W+PRIO_W];
      arg2_q <= s_axis_tdata[SLOT_W+PRIO_W+2*ARG_W-1:SLOT_W+PRIO_W+ARG_W];
    end
    if (commit) begin
      done_q   <= done_d;
      raise_q  <= raise_d;
      popped_q <= pop_d;
      pslot_q  <= pop_d ? SLOT_W'(head_q) : '0;
      empty_q  <= (depth_d == '0);
      qdepth_q <= (32'(depth_d) > 63) ? DEPTH_W'(63) : DEPTH_W'(depth_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, qdepth_q, empty_q,
                          popped_q ? arg_rd_q : {2*ARG_W{1'b0}},
                          pslot_q, raise_q, done_q};

  `DWPQ_ASSERT(a_depth_matches_marks, clk_i, rst_ni, $countones(mark_q) == 32'(depth_q))
  `DWPQ_ASSERT(a_raise_sets_pending, clk_i, rst_ni, commit && raise_d |=> pending_q)
  `DWPQ_ASSERT(a_pop_needs_entries, clk_i, rst_ni, commit && pop_d |-> depth_q != '0)
  `DWPQ_NEVER(a_ready_when_free, clk_i, rst_ni, !in_valid_q && !s_axis_tready)

endmodule

### tb/deferred_work_queue_checker.sv
module deferred_work_queue_checker
  import dwpq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     req_valid_i,
  input  logic                     req_ready_i,
  // object_slot, priority_level, first_argument, second_argument, zero pad
  input  logic [IN_DATA_W-1:0]     req_data_i,
  // command
  input  logic [1:0]               req_cmd_i,
  input  logic                     res_valid_i,
  input  logic                     res_ready_i,
  // done_res, raise_interrupt, popped_slot, popped_first_argument,
  // popped_second_argument, queue_empty, queue_depth, zero pad
  input  logic [OUT_DATA_W-1:0]    res_data_i,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [THR_W-1:0]         cfg_data_i,
  output int unsigned              mismatches_o,
  output int unsigned              outstanding_o,
  output logic [NUM_SLOTS_DEF-1:0] queued_slots_o,
  output int unsigned              results_o,
  output int unsigned              pops_o,
  output int unsigned              irqs_o,
  output int unsigned              peak_depth_o
);

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic               empty;
    logic [ARG_W-1:0]   arg2;
    logic [ARG_W-1:0]   arg1;
    logic [SLOT_W-1:0]  slot;
    logic               irq;
    logic               done;
  } step_result_t;

  logic [NUM_SLOTS_DEF-1:0] queued;
  logic [SLOT_W-1:0]        next_slot [NUM_SLOTS_DEF];
  logic [SLOT_W-1:0]        prev_slot [NUM_SLOTS_DEF];
  logic [ARG_W-1:0]         first_word [NUM_SLOTS_DEF];
  logic [ARG_W-1:0]         second_word [NUM_SLOTS_DEF];
  logic [SLOT_W-1:0]        head;
  logic [SLOT_W-1:0]        tail;
  int unsigned              depth;
  bit                       retiring;
  bit                       pending;
  logic [THR_W-1:0]         threshold;

  step_result_t             expected_results [$];
  int unsigned              mismatches;
  int unsigned              results;
  int unsigned              pops;
  int unsigned              irqs;
  int unsigned              peak_depth;

  function automatic void unlink(logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] nx;
    logic [SLOT_W-1:0] pv;
    nx = next_slot[s];
    pv = prev_slot[s];
    if (depth > 1) begin
      if (s == head) begin
        head = nx;
      end else if (s == tail) begin
        tail = pv;
      end else begin
        next_slot[pv] = nx;
        prev_slot[nx] = pv;
      end
    end
    queued[s] = 1'b0;
    if (depth != 0) depth--;
  endfunction

  function automatic step_result_t queue_step(cmd_e cmd, logic [SLOT_W-1:0] s,
                                              logic [PRIO_W-1:0] prio,
                                              logic [ARG_W-1:0] a1,
                                              logic [ARG_W-1:0] a2);
    step_result_t r;
    r = '0;
    case (cmd)
      CMD_INSERT: begin
        if (!queued[s]) begin
          depth++;
          first_word[s] = a1;
          second_word[s] = a2;
          if (depth == 1) begin
            head = s;
            tail = s;
          end else if (prio >= PRIO_HIGH) begin
            next_slot[s] = head;
            prev_slot[head] = s;
            head = s;
          end else begin
            prev_slot[s] = tail;
            next_slot[tail] = s;
            tail = s;
          end
          queued[s] = 1'b1;
          r.done = 1'b1;
          if (!retiring && !pending && (prio != PRIO_LOW || depth >= threshold)) begin
            pending = 1'b1;
            r.irq = 1'b1;
          end
        end
      end
      CMD_REMOVE: begin
        if (queued[s]) begin
          unlink(s);
          r.done = 1'b1;
        end
      end
      CMD_RETIRE: begin
        if (depth == 0) begin
          retiring = 1'b0;
          pending = 1'b0;
        end else begin
          retiring = 1'b1;
          r.slot = head;
          r.arg1 = first_word[head];
          r.arg2 = second_word[head];
          unlink(head);
          r.done = 1'b1;
        end
      end
      default: begin
        pending = 1'b1;
        r.irq = !retiring;
      end
    endcase
    r.empty = (depth == 0);
    r.depth = (depth > 63) ? 6'd63 : DEPTH_W'(depth);
    return r;
  endfunction

  function automatic void compare_field(string name, logic [ARG_W-1:0] want,
                                        logic [ARG_W-1:0] got);
    if (got !== want) begin
      if (mismatches < 10) begin
        $display("Result %0d: %s expected %h, got %h", results, name, want, got);
      end
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    step_result_t got;
    step_result_t want;
    if (!rst_ni) begin
      queued = '0;
      for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
        next_slot[i] = '0;
        prev_slot[i] = '0;
        first_word[i] = '0;
        second_word[i] = '0;
      end
      head = '0;
      tail = '0;
      depth = 0;
      retiring = 1'b0;
      pending = 1'b0;
      threshold = THRESHOLD_RESET;
      expected_results.delete();
      mismatches = 0;
      results = 0;
      pops = 0;
      irqs = 0;
      peak_depth = 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        got = res_data_i[$bits(step_result_t)-1:0];
        if (expected_results.size() == 0) begin
          if (mismatches < 10) begin
            $display("Result with no request outstanding: %h", res_data_i);
          end
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          compare_field("done_res", want.done, got.done);
          compare_field("raise_interrupt", want.irq, got.irq);
          compare_field("popped_slot", want.slot, got.slot);
          compare_field("popped_first_argument", want.arg1, got.arg1);
          compare_field("popped_second_argument", want.arg2, got.arg2);
          compare_field("queue_empty", want.empty, got.empty);
          compare_field("queue_depth", want.depth, got.depth);
        end
        results++;
      end
      if (cfg_valid_i && cfg_ready_i) threshold = cfg_data_i;
      if (req_valid_i && req_ready_i) begin
        want = queue_step(cmd_e'(req_cmd_i), req_data_i[SLOT_W-1:0],
                          req_data_i[SLOT_W +: PRIO_W],
                          req_data_i[SLOT_W+PRIO_W +: ARG_W],
                          req_data_i[SLOT_W+PRIO_W+ARG_W +: ARG_W]);
        if (cmd_e'(req_cmd_i) == CMD_RETIRE && want.done) pops++;
        if (want.irq) irqs++;
        if (depth > peak_depth) peak_depth = depth;
        expected_results.push_back(want);
      end
    end
    mismatches_o <= mismatches;
    outstanding_o <= expected_results.size();
    queued_slots_o <= queued;
    results_o <= results;
    pops_o <= pops;
    irqs_o <= irqs;
    peak_depth_o <= peak_depth;
  end

endmodule

### tb/deferred_work_priority_queue_tb.sv
module deferred_work_priority_queue_tb
  import dwpq_pkg::*;
();

  localparam logic [PRIO_W-1:0] PRIO_MEDIUM = 2'd1;
  localparam logic [PRIO_W-1:0] PRIO_TOP    = 2'd3;
  localparam int unsigned LONG_HOLD  = 400;
  localparam int unsigned IDLE_LIMIT = 3000;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [IN_DATA_W-1:0]     s_axis_tdata;
  logic [1:0]               s_axis_tuser;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  logic [OUT_DATA_W-1:0]    m_axis_tdata;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [THR_W-1:0]         cfg_data_i;

  int unsigned              mismatches;
  int unsigned              outstanding;
  logic [NUM_SLOTS_DEF-1:0] live_slots;
  int unsigned              results;
  int unsigned              pops;
  int unsigned              irqs;
  int unsigned              peak_depth;

  bit                       hold_off_req;
  bit                       tx_steady;
  bit                       rx_steady;
  int unsigned              requests_sent;
  int unsigned              idle_cycles;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  deferred_work_priority_queue dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  deferred_work_queue_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (s_axis_tvalid),
    .req_ready_i    (s_axis_tready),
    .req_data_i     (s_axis_tdata),
    .req_cmd_i      (s_axis_tuser),
    .res_valid_i    (m_axis_tvalid),
    .res_ready_i    (m_axis_tready),
    .res_data_i     (m_axis_tdata),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .mismatches_o   (mismatches),
    .outstanding_o  (outstanding),
    .queued_slots_o (live_slots),
    .results_o      (results),
    .pops_o         (pops),
    .irqs_o         (irqs),
    .peak_depth_o   (peak_depth)
  );

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SLOT_W-1:0] pick_slot(bit want_queued);
    logic [SLOT_W-1:0] s;
    s = SLOT_W'($urandom_range(NUM_SLOTS_DEF - 1));
    for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
      if (live_slots[s] == want_queued) return s;
      s = s + 1'b1;
    end
    return s;
  endfunction

  function automatic logic [ARG_W-1:0] random_word();
    int unsigned r;
    r = $urandom_range(19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  task automatic send_request(cmd_e cmd, logic [SLOT_W-1:0] s, logic [PRIO_W-1:0] prio,
                              logic [ARG_W-1:0] a1, logic [ARG_W-1:0] a2);
    int unsigned gap;
    gap = tx_steady ? 0 : gap_len();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {1'b0, a2, a1, prio, s};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    requests_sent++;
  endtask

  task automatic send_random(int unsigned insert_pct);
    int unsigned roll;
    int unsigned rest;
    cmd_e cmd;
    logic [SLOT_W-1:0] s;
    logic [PRIO_W-1:0] prio;
    roll = $urandom_range(99);
    rest = 100 - insert_pct;
    if (roll < insert_pct) cmd = CMD_INSERT;
    else if (roll < insert_pct + rest * 3 / 10) cmd = CMD_REMOVE;
    else if (roll < insert_pct + rest * 8 / 10) cmd = CMD_RETIRE;
    else cmd = CMD_DISPATCH;
    if (cmd == CMD_INSERT) s = pick_slot($urandom_range(9) == 0);
    else if (cmd == CMD_REMOVE) s = ($urandom_range(6) == 0) ? pick_slot(1'b0) : pick_slot(1'b1);
    else s = SLOT_W'($urandom);
    roll = $urandom_range(99);
    if (roll < 40) prio = PRIO_LOW;
    else if (roll < 65) prio = PRIO_MEDIUM;
    else if (roll < 95) prio = PRIO_HIGH;
    else prio = PRIO_TOP;
    send_request(cmd, s, prio, random_word(), random_word());
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (outstanding == 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(logic [THR_W-1:0] value, int unsigned count,
                           int unsigned insert_pct, bit calm, bit squeeze);
    drain_results();
    write_threshold(value);
    tx_steady = calm;
    rx_steady = calm;
    for (int i = 0; i < count; i++) begin
      if (squeeze && i == count / 4) begin
        hold_off_req = 1'b1;
        tx_steady = 1'b1;
      end
      if (squeeze && i == count / 4 + 40) tx_steady = calm;
      if (i == count / 2) begin
        tx_steady = 1'b0;
        rx_steady = 1'b0;
      end
      if (i == count * 3 / 4) drain_results();
      send_random(insert_pct);
    end
  endtask

  initial begin
    m_axis_tready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      int unsigned n;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      n = rx_steady ? 0 : gap_len();
      if (n != 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding.", outstanding);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = CMD_INSERT;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    hold_off_req = 1'b0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    requests_sent = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed sequence runs at the reset threshold.
    send_request(CMD_DISPATCH, 5'd0, PRIO_LOW, '0, '0);
    send_request(CMD_INSERT, 5'd0, PRIO_LOW, '0, '0);
    send_request(CMD_RETIRE, 5'd0, PRIO_LOW, '0, '0);
    send_request(CMD_RETIRE, 5'd0, PRIO_LOW, '0, '0);
    send_request(CMD_INSERT, 5'd31, PRIO_HIGH, '1, '1);
    send_request(CMD_INSERT, 5'd3, PRIO_MEDIUM, 64'h0123_4567_89ab_cdef,
                 64'hfedc_ba98_7654_3210);
    send_request(CMD_INSERT, 5'd4, PRIO_TOP, 64'haaaa_aaaa_aaaa_aaaa,
                 64'h5555_5555_5555_5555);
    send_request(CMD_INSERT, 5'd31, PRIO_LOW, 64'h1, 64'h2);
    send_request(CMD_INSERT, 5'd9, PRIO_LOW, 64'h5555_5555_5555_5555,
                 64'haaaa_aaaa_aaaa_aaaa);
    send_request(CMD_REMOVE, 5'd31, PRIO_LOW, '0, '0);
    send_request(CMD_REMOVE, 5'd31, PRIO_LOW, '0, '0);
    send_request(CMD_REMOVE, 5'd9, PRIO_LOW, '0, '0);
    send_request(CMD_REMOVE, 5'd4, PRIO_LOW, '0, '0);
    send_request(CMD_RETIRE, 5'd0, PRIO_LOW, '0, '0);
    send_request(CMD_DISPATCH, 5'd0, PRIO_LOW, '0, '0);
    send_request(CMD_RETIRE, 5'd0, PRIO_LOW, '0, '0);
    send_request(CMD_INSERT, 5'd1, PRIO_LOW, 64'h8000_0000_0000_0001, '0);
    send_request(CMD_INSERT, 5'd2, PRIO_LOW, '0, 64'h8000_0000_0000_0001);
    send_request(CMD_INSERT, 5'd6, PRIO_LOW, 64'h7fff_ffff_ffff_fffe, '1);
    send_request(CMD_INSERT, 5'd8, PRIO_LOW, '1, 64'h7fff_ffff_ffff_fffe);
    send_request(CMD_RETIRE, 5'd0, PRIO_LOW, '0, '0);
    send_request(CMD_RETIRE, 5'd0, PRIO_LOW, '0, '0);
    send_request(CMD_RETIRE, 5'd0, PRIO_LOW, '0, '0);
    send_request(CMD_RETIRE, 5'd0, PRIO_LOW, '0, '0);
    send_request(CMD_RETIRE, 5'd0, PRIO_LOW, '0, '0);

    run_phase(6'd1, 200, 50, 1'b0, 1'b0);
    run_phase(6'd32, 200, 65, 1'b0, 1'b1);
    run_phase(6'd0, 130, 45, 1'b0, 1'b0);
    run_phase(6'd63, 130, 55, 1'b0, 1'b0);
    run_phase(THR_W'($urandom_range(2, 31)), 140, 50, 1'b1, 1'b0);

    drain_results();
    repeat (8) @(posedge clk_i);

    $display("Sent %0d requests and checked %0d results: %0d pops, %0d interrupt requests.",
             requests_sent, results, pops, irqs);
    $display("Queue depth peaked at %0d over six threshold settings and one long output stall.",
             peak_depth);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
